// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Shared sizes, opcode and status codes, and the table write request type
// for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 16;
    localparam int ID_BITS     = 16;
    localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // one write into the entry store
    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } wr_req_t;

endpackage

// ----- hdl/skt_table.sv -----
// ----------------------------------------------------------------------------
// skt_table
// Entry store: identifier and key memories with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module skt_table (
    input  logic                         clk,
    input  skt_pkg::wr_req_t             wr_req,
    input  logic                         rd_en,
    input  logic [skt_pkg::IDX_BITS-1:0] rd_addr,
    output logic [skt_pkg::ID_BITS-1:0]  rd_id,
    output logic [skt_pkg::KEY_BITS-1:0] rd_key
);
    import skt_pkg::*;

    logic [ID_BITS-1:0]  id_mem  [TABLE_DEPTH];
    logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            id_mem[wr_req.addr]  <= wr_req.id;
            key_mem[wr_req.addr] <= wr_req.key;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id  <= id_mem[rd_addr];
            rd_key <= key_mem[rd_addr];
        end
    end

endmodule

// ----- hdl/sorted_key_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Bounded table of identifier and key entries kept in ascending key order,
// walked one entry at a time by a small sequencer over one write port and one read port.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries opcode, key_id and key_units;
//   a transfer happens when in_valid is high and in_stall is low.
//   output channel (out_valid / out_stall) carries status, found_units and
//   entry_count, one result per input transfer, in order.
//   insert walks down from the tail, one compare per entry, moving each
//   larger entry up one slot, then writes the new entry into the slot left
//   free, or at the head when every held entry is larger.
//   find walks up from the head comparing identifiers. remove finds the
//   entry the same way, then moves every entry after the hit down one slot
//   to close the gap. a full insert or the unused opcode goes straight to
//   the result without touching the store. each entry visit takes a read
//   step and a compare step because the store read port is registered.
//   in_stall stays high while an item is in work; the next item is taken as
//   soon as the sequencer is idle, even while a result still waits.
//   a stalled result holds in the output register; a finished item waits
//   for that register before it is delivered.
//   reset empties the table at once (count zero); no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] key_id,
    input  logic [15:0] key_units,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] found_units,
    output logic [4:0]  entry_count
);
    import skt_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CHK = 3'd2;
    localparam logic [2:0] S_SRC_RD  = 3'd3;
    localparam logic [2:0] S_SRC_CHK = 3'd4;
    localparam logic [2:0] S_SHF_RD  = 3'd5;
    localparam logic [2:0] S_SHF_WR  = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] occ_reg, occ_next;
    logic [CNT_BITS-1:0] ptr_reg, ptr_next;
    logic [1:0]          op_reg, op_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [KEY_BITS-1:0] res_units_reg, res_units_next;

    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [15:0]         found_reg;
    logic [4:0]          count_reg;

    wr_req_t             wr_req;
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_addr;
    logic [ID_BITS-1:0]  rd_id;
    logic [KEY_BITS-1:0] rd_key;
    logic                in_xfer;
    logic                out_free;
    logic                resp_load;

    skt_table u_table (
        .clk     (clk),
        .wr_req  (wr_req),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_id   (rd_id),
        .rd_key  (rd_key)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign resp_load = (state_reg == S_RESP) && out_free;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_units_next  = res_units_reg;
        wr_req          = '0;
        wr_req.id       = rd_id;
        wr_req.key      = rd_key;
        rd_en           = 1'b0;
        rd_addr         = IDX_BITS'(ptr_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next         = opcode;
                    id_next         = ID_BITS'(key_id);
                    key_next        = KEY_BITS'(key_units);
                    res_status_next = ST_DONE;
                    res_units_next  = '0;
                    ptr_next        = (opcode == OP_INSERT) ? occ_reg : '0;
                    case (opcode) inside
                        OP_INSERT:
                        begin
                            if (occ_reg == CNT_BITS'(TABLE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        OP_REMOVE, OP_FIND:
                            state_next = S_SRC_RD;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end

            // insert: fetch the entry below the write slot, or place at head
            S_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    wr_req.en   = 1'b1;
                    wr_req.addr = '0;
                    wr_req.id   = id_reg;
                    wr_req.key  = key_reg;
                    occ_next    = occ_reg + 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_BITS'(ptr_reg - 1'b1);
                    state_next = S_INS_CHK;
                end
            end

            // insert: move a larger entry up, or place the new one here
            S_INS_CHK:
            begin
                wr_req.en   = 1'b1;
                wr_req.addr = IDX_BITS'(ptr_reg);
                if (rd_key > key_reg)
                begin
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    wr_req.id  = id_reg;
                    wr_req.key = key_reg;
                    occ_next   = occ_reg + 1'b1;
                    state_next = S_RESP;
                end
            end

            // remove / find: fetch next entry or report a miss
            S_SRC_RD:
            begin
                if (ptr_reg == occ_reg)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SRC_CHK;
                end
            end

            // remove / find: identifier compare
            S_SRC_CHK:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (rd_id == id_reg)
                begin
                    res_units_next = rd_key;
                    state_next     = (op_reg == OP_REMOVE) ? S_SHF_RD : S_RESP;
                end
                else
                begin
                    state_next = S_SRC_RD;
                end
            end

            // remove: fetch the entry after the gap, or finish
            S_SHF_RD:
            begin
                if (ptr_reg == occ_reg)
                begin
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SHF_WR;
                end
            end

            // remove: move the entry down one slot
            S_SHF_WR:
            begin
                wr_req.en   = 1'b1;
                wr_req.addr = IDX_BITS'(ptr_reg - 1'b1);
                ptr_next    = ptr_reg + 1'b1;
                state_next  = S_SHF_RD;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        op_reg         <= op_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_units_reg  <= res_units_next;
        if (resp_load)
        begin
            status_reg <= res_status_reg;
            found_reg  <= 16'(res_units_reg);
            count_reg  <= 5'(occ_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_units = found_reg;
    assign entry_count = count_reg;

endmodule

// ----- tb/sorted_key_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// Watches both channels of the sorted key table, keeps its own ordered copy
// of the entries, and compares every result transfer with the expected one.
// ----------------------------------------------------------------------------
module sorted_key_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] key_id,
    input  logic [15:0] key_units,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [15:0] found_units,
    input  logic [4:0]  entry_count,
    output int          failures,
    output int          pending
);
    import skt_pkg::*;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] units;
        logic [CNT_BITS-1:0] count;
    } table_result_t;

    // shadow copy of the entry store, ascending by key
    logic [ID_BITS-1:0]  shadow_ids  [TABLE_DEPTH];
    logic [KEY_BITS-1:0] shadow_keys [TABLE_DEPTH];
    int                  held;

    table_result_t       expected_results [$];

    initial
    begin
        failures = 0;
        held     = 0;
    end

    assign pending = expected_results.size();

    task automatic report_failure(input string msg);
        $display("%0t ns sorted_key_table_checker: %s", $time, msg);
        failures++;
    endtask

    // apply one operation to the shadow table and return its result
    function automatic table_result_t apply_table_op(
        input logic [1:0]          op,
        input logic [ID_BITS-1:0]  id,
        input logic [KEY_BITS-1:0] units
    );
        table_result_t r;
        int            pos;
        int            hit;
        int            i;
        r.status = ST_DONE;
        r.units  = '0;
        case (op) inside
            OP_INSERT:
            begin
                if (held >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // equal keys go behind the ones already held
                    pos = 0;
                    while (pos < held && shadow_keys[pos] <= units)
                        pos++;
                    for (i = held; i > pos; i--)
                    begin
                        shadow_ids[i]  = shadow_ids[i-1];
                        shadow_keys[i] = shadow_keys[i-1];
                    end
                    shadow_ids[pos]  = id;
                    shadow_keys[pos] = units;
                    held++;
                end
            end
            OP_REMOVE, OP_FIND:
            begin
                // first match in table order
                hit = -1;
                for (i = 0; i < held; i++)
                    if (hit < 0 && shadow_ids[i] == id)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.units = shadow_keys[hit];
                    if (op == OP_REMOVE)
                    begin
                        for (i = hit; i + 1 < held; i++)
                        begin
                            shadow_ids[i]  = shadow_ids[i+1];
                            shadow_keys[i] = shadow_keys[i+1];
                        end
                        held--;
                    end
                end
            end
            default:
                r.status = ST_DONE;
        endcase
        r.count = CNT_BITS'(held);
        return r;
    endfunction

    // compare result transfers first, then predict from input transfers
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_failure($sformatf("result with nothing expected: %0d %0h %0d",
                                             status, found_units, entry_count));
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_failure($sformatf("status got %0d expected %0d",
                                                 status, want.status));
                    if (found_units !== want.units)
                        report_failure($sformatf("found_units got %0h expected %0h",
                                                 found_units, want.units));
                    if (entry_count !== want.count)
                        report_failure($sformatf("entry_count got %0d expected %0d",
                                                 entry_count, want.count));
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_table_op(opcode, key_id, key_units));
        end
    end

endmodule

// ----- tb/sorted_key_table_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_top_test
// Drives the sorted key table with a directed pass over full, empty, equal
// key and duplicate identifier cases, then phases of fill, drain and mixed
// random traffic under random idling on both channels.
// ----------------------------------------------------------------------------
module sorted_key_table_top_test;
    import skt_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 850;
    localparam int         QUIET_ITEMS  = 100;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [15:0] key_id;
    logic [15:0] key_units;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] found_units;
    logic [4:0]  entry_count;
    int          failures;
    int          pending;

    // 0 no idling, 1 light, 2 heavy
    int          idle_mode;

    sorted_key_table_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .key_id      (key_id),
        .key_units   (key_units),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_units (found_units),
        .entry_count (entry_count)
    );

    sorted_key_table_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .key_id      (key_id),
        .key_units   (key_units),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_units (found_units),
        .entry_count (entry_count),
        .failures    (failures),
        .pending     (pending)
    );

    // clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard limit on run length
    initial
    begin
        #1000000;
        $display("[sorted_key_table_top] ERROR");
        $finish;
    end

    function automatic bit idle_now();
        case (idle_mode)
            1:       return $urandom_range(0, 7) == 0;
            2:       return $urandom_range(0, 2) == 0;
            default: return 1'b0;
        endcase
    endfunction

    // result side stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_now())
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one input transfer, then maybe an idle burst; called at a falling edge
    task automatic send_item(input logic [1:0] op, input logic [15:0] id,
                             input logic [15:0] units);
        opcode    <= op;
        key_id    <= id;
        key_units <= units;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (idle_now())
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // identifiers mostly from a small pool so remove and find often hit
    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'hffff;
            default: return 16'($urandom_range(0, 13));
        endcase
    endfunction

    // keys: extremes, a narrow band for ties, or anything
    function automatic logic [15:0] pick_units();
        case ($urandom_range(0, 7)) inside
            0:       return 16'h0000;
            1:       return 16'hffff;
            2, 3:    return 16'($urandom_range(0, 5));
            default: return 16'($urandom);
        endcase
    endfunction

    // opcode weighted by phase: 0 fill, 1 drain, 2 mixed
    function automatic logic [1:0] pick_op(input int phase);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return OP_UNUSED;
        case (phase)
            0:       return (roll < 75) ? OP_INSERT : ((roll < 88) ? OP_FIND : OP_REMOVE);
            1:       return (roll < 20) ? OP_INSERT : ((roll < 40) ? OP_FIND : OP_REMOVE);
            default: return (roll < 45) ? OP_INSERT : ((roll < 72) ? OP_FIND : OP_REMOVE);
        endcase
    endfunction

    initial
    begin
        int phase;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = OP_INSERT;
        key_id    = '0;
        key_units = '0;
        idle_mode = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table: misses and the unused opcode
        idle_mode = 1;
        send_item(OP_FIND,   16'h0000, 16'h0000);
        send_item(OP_REMOVE, 16'hffff, 16'hffff);
        send_item(OP_UNUSED, 16'hffff, 16'hffff);

        // fill to the top with ties, duplicate identifiers and key extremes
        send_item(OP_INSERT, 16'd1,    16'hffff);
        send_item(OP_INSERT, 16'd2,    16'h0000);
        send_item(OP_INSERT, 16'd3,    16'hffff);
        send_item(OP_INSERT, 16'd4,    16'h8000);
        send_item(OP_INSERT, 16'd1,    16'h0000);
        send_item(OP_INSERT, 16'd5,    16'h7fff);
        send_item(OP_INSERT, 16'd6,    16'h0001);
        send_item(OP_INSERT, 16'd7,    16'hfffe);
        send_item(OP_INSERT, 16'd8,    16'h8000);
        send_item(OP_INSERT, 16'd9,    16'h1234);
        send_item(OP_INSERT, 16'd10,   16'haaaa);
        send_item(OP_INSERT, 16'd11,   16'h5555);
        send_item(OP_INSERT, 16'd12,   16'h0000);
        send_item(OP_INSERT, 16'd13,   16'hffff);
        send_item(OP_INSERT, 16'd14,   16'h0f0f);
        send_item(OP_INSERT, 16'hffff, 16'hf0f0);

        // insert into a full table
        send_item(OP_INSERT, 16'h0000, 16'h1234);

        // first duplicate wins, then tail, head and duplicate removal
        send_item(OP_FIND,   16'd1,    16'h5a5a);
        send_item(OP_FIND,   16'hffff, 16'h0000);
        send_item(OP_REMOVE, 16'd13,   16'hffff);
        send_item(OP_REMOVE, 16'd2,    16'h0000);
        send_item(OP_REMOVE, 16'd1,    16'ha5a5);

        // random phases of 50 items, the tail end without idling
        phase = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                phase     = $urandom_range(0, 2);
                idle_mode = $urandom_range(0, 2);
            end
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_mode = 0;
            send_item(pick_op(phase), pick_id(), pick_units());
        end
        in_valid <= 1'b0;

        // drain outstanding results, then allow the longest item to settle
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("[sorted_key_table_top] OK");
        else
            $display("[sorted_key_table_top] ERROR");
        $finish;
    end

endmodule
